// ===== design/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, character codes and keyword table of the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int KW_MAX_LEN_DEF  = 11;
    localparam int OFFSET_BITS_DEF = 24;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_TILDE      = 8'h7E;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_QUOTE      = 8'h22;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUMBER,
        MODE_STRING,
        MODE_LCOMMENT,
        MODE_BCOMMENT
    } t_mode;

    typedef enum logic [2:0] {
        KIND_KEYWORD,
        KIND_IDENT,
        KIND_NUMBER,
        KIND_SYMBOL,
        KIND_STRING
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] length;
        logic [15:0] line;
        logic [15:0] column;
        logic        last;
    } t_rec;

    localparam int KW_COUNT = 21;
    localparam int KW_BYTES = 11;

    // text right-justified, first character in the highest used byte
    localparam logic [KW_BYTES*8-1:0] KW_TEXT [KW_COUNT] = '{
        "class", "constructor", "function", "method", "field", "static",
        "var", "int", "char", "boolean", "void", "true", "false", "null",
        "this", "let", "do", "if", "else", "while", "return"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd11, 4'd8, 4'd6, 4'd5, 4'd6, 4'd3, 4'd3, 4'd4, 4'd7, 4'd4,
        4'd4, 4'd5, 4'd4, 4'd4, 4'd3, 4'd2, 4'd2, 4'd4, 4'd5, 4'd6
    };

    // text holds word byte j at bits [j*8 +: 8]
    function automatic logic kw_hit(input logic [KW_BYTES*8-1:0] text,
                                    input logic [15:0] len);
        logic hit;
        logic m;
        hit = 1'b0;
        for (int i = 0; i < KW_COUNT; i++) begin
            m = (len == 16'(KW_LEN[i]));
            for (int j = 0; j < KW_BYTES; j++) begin
                if (j < int'(KW_LEN[i])) begin
                    m = m && (text[j*8 +: 8] ==
                              KW_TEXT[i][(int'(KW_LEN[i]) - 1 - j)*8 +: 8]);
                end
            end
            hit = hit | m;
        end
        return hit;
    endfunction

endpackage

// ===== design/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front
// Lexer front end: holds one byte of lookahead, tracks position and the open
// token, and produces up to two token records per accepted transaction.
// ----------------------------------------------------------------------------
module stt_front #(
    parameter int KEYWORD_MAX_LEN = stt_pkg::KW_MAX_LEN_DEF,
    parameter int OFFSET_BITS     = stt_pkg::OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_char_code,
    input  logic                   i_end_of_input,
    input  logic                   i_full,
    output logic                   o_stall,
    output logic [1:0]             o_push_cnt,
    output stt_pkg::t_rec          o_rec0,
    output stt_pkg::t_rec          o_rec1,
    output logic [OFFSET_BITS-1:0] o_off0,
    output logic [OFFSET_BITS-1:0] o_off1
);
    import stt_pkg::*;

    localparam int                     IDX_W   = $clog2(KEYWORD_MAX_LEN);
    localparam logic [15:0]            KW_MAX  = 16'(KEYWORD_MAX_LEN);
    localparam logic [15:0]            MAX16   = 16'hFFFF;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               c == CH_UNDERSCORE;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_break(input logic [7:0] c);
        return c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        logic s;
        case (c)
            8'h26, 8'h7C, 8'h3D, 8'h3C, 8'h3E, 8'h2B, 8'h2D, CH_STAR, CH_SLASH,
            8'h2E, 8'h2C, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, CH_TILDE,
            CH_SEMI: s = 1'b1;
            default: s = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] sat16(input logic [15:0] v);
        return (v != MAX16) ? v + 16'd1 : v;
    endfunction

    t_mode                  r_mode, n_mode;
    logic [7:0]             r_held;
    logic                   r_held_valid;
    logic                   r_consume, n_consume;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [15:0]            r_line, n_line;
    logic [15:0]            r_col, n_col;
    logic [OFFSET_BITS-1:0] r_open_off, n_open_off;
    logic [15:0]            r_open_line, n_open_line;
    logic [15:0]            r_open_col, n_open_col;
    logic [15:0]            r_len, n_len;
    logic [7:0]             r_prefix [KEYWORD_MAX_LEN];

    logic                   acc;
    logic                   nv;
    logic                   do_cls;
    logic                   pw_en;
    logic [IDX_W-1:0]       pw_idx;
    logic [KW_BYTES*8-1:0]  pre_text;
    logic [KW_BYTES*8-1:0]  post_text;
    t_kind                  pre_kind;
    t_kind                  post_kind;

    logic                   p_v;
    t_kind                  p_kind;
    logic                   s_v;
    logic                   f_v;
    t_kind                  f_kind;
    t_rec                   rec_p, rec_s, rec_f;
    logic [1:0]             cnt;

    assign acc     = i_valid && !i_full;
    assign o_stall = i_full;
    assign nv      = !i_end_of_input;

    always_comb begin
        for (int j = 0; j < KW_BYTES; j++) begin
            pre_text[j*8 +: 8]  = r_prefix[j];
            post_text[j*8 +: 8] = (pw_en && int'(pw_idx) == j) ? r_held : r_prefix[j];
        end
    end

    assign pre_kind  = (r_len <= KW_MAX && kw_hit(pre_text, r_len)) ? KIND_KEYWORD
                                                                     : KIND_IDENT;
    assign post_kind = (n_len <= KW_MAX && kw_hit(post_text, n_len)) ? KIND_KEYWORD
                                                                      : KIND_IDENT;

    // held byte processing and position advance
    always_comb begin
        n_mode      = r_mode;
        n_consume   = r_consume;
        n_pos       = r_pos;
        n_line      = r_line;
        n_col       = r_col;
        n_open_off  = r_open_off;
        n_open_line = r_open_line;
        n_open_col  = r_open_col;
        n_len       = r_len;
        pw_en       = 1'b0;
        pw_idx      = r_len[IDX_W-1:0];
        p_v         = 1'b0;
        p_kind      = KIND_IDENT;
        s_v         = 1'b0;
        do_cls      = 1'b0;
        if (r_held_valid) begin
            if (r_consume) begin
                n_consume = 1'b0;
            end else begin
                case (r_mode)
                    MODE_WORD: begin
                        if (is_letter(r_held) || is_digit(r_held)) begin
                            pw_en = (r_len < KW_MAX);
                            n_len = sat16(r_len);
                        end else begin
                            p_v    = 1'b1;
                            p_kind = pre_kind;
                            n_mode = MODE_IDLE;
                            do_cls = 1'b1;
                        end
                    end
                    MODE_NUMBER: begin
                        if (is_digit(r_held)) begin
                            n_len = sat16(r_len);
                        end else begin
                            p_v    = 1'b1;
                            p_kind = KIND_NUMBER;
                            n_mode = MODE_IDLE;
                            do_cls = 1'b1;
                        end
                    end
                    MODE_STRING: begin
                        if (r_held == CH_QUOTE || is_break(r_held)) begin
                            p_v    = 1'b1;
                            p_kind = KIND_STRING;
                            n_mode = MODE_IDLE;
                        end else begin
                            n_len = sat16(r_len);
                        end
                    end
                    MODE_LCOMMENT: begin
                        if (is_break(r_held)) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_BCOMMENT: begin
                        if (r_held == CH_STAR && nv && i_char_code == CH_SLASH) begin
                            n_mode    = MODE_IDLE;
                            n_consume = 1'b1;
                        end
                    end
                    default: begin
                        n_mode = MODE_IDLE;
                        do_cls = 1'b1;
                    end
                endcase
                if (do_cls) begin
                    if (is_letter(r_held)) begin
                        n_mode      = MODE_WORD;
                        n_open_off  = r_pos;
                        n_open_line = r_line;
                        n_open_col  = r_col;
                        n_len       = 16'd1;
                        pw_en       = 1'b1;
                        pw_idx      = '0;
                    end else if (is_digit(r_held)) begin
                        n_mode      = MODE_NUMBER;
                        n_open_off  = r_pos;
                        n_open_line = r_line;
                        n_open_col  = r_col;
                        n_len       = 16'd1;
                    end else if (r_held == CH_QUOTE) begin
                        n_mode      = MODE_STRING;
                        n_open_off  = (r_pos != OFF_MAX) ? r_pos + 1'b1 : r_pos;
                        n_open_line = r_line;
                        n_open_col  = sat16(r_col);
                        n_len       = 16'd0;
                    end else if (r_held == CH_SLASH && nv && i_char_code == CH_SLASH) begin
                        n_mode    = MODE_LCOMMENT;
                        n_consume = 1'b1;
                    end else if (r_held == CH_SLASH && nv && i_char_code == CH_STAR) begin
                        n_mode    = MODE_BCOMMENT;
                        n_consume = 1'b1;
                    end else if (is_symbol(r_held)) begin
                        s_v = 1'b1;
                    end
                end
            end
            if (is_break(r_held)) begin
                n_line = sat16(r_line);
                n_col  = 16'd0;
            end else begin
                n_col = sat16(r_col);
            end
            n_pos = (r_pos != OFF_MAX) ? r_pos + 1'b1 : r_pos;
        end
    end

    // end of input flush
    always_comb begin
        f_v    = i_end_of_input && (n_mode == MODE_WORD || n_mode == MODE_NUMBER);
        f_kind = (n_mode == MODE_WORD) ? post_kind : KIND_NUMBER;
    end

    // record ordering
    always_comb begin
        rec_p = '{kind: p_kind, length: r_len, line: r_open_line, column: r_open_col,
                  last: 1'b0};
        rec_s = '{kind: KIND_SYMBOL, length: 16'd1, line: r_line, column: r_col,
                  last: 1'b0};
        rec_f = '{kind: f_kind, length: n_len, line: n_open_line, column: n_open_col,
                  last: 1'b0};
        o_rec0 = rec_f;
        o_off0 = n_open_off;
        o_rec1 = rec_f;
        o_off1 = n_open_off;
        cnt    = 2'd0;
        if (p_v) begin
            o_rec0 = rec_p;
            o_off0 = r_open_off;
            if (s_v) begin
                o_rec1 = rec_s;
                o_off1 = r_pos;
                cnt    = 2'd2;
            end else if (f_v) begin
                cnt = 2'd2;
            end else begin
                cnt = 2'd1;
            end
        end else if (s_v) begin
            o_rec0 = rec_s;
            o_off0 = r_pos;
            cnt    = f_v ? 2'd2 : 2'd1;
        end else if (f_v) begin
            cnt = 2'd1;
        end
        if (cnt == 2'd1) begin
            o_rec0.last = 1'b1;
        end else if (cnt == 2'd2) begin
            o_rec1.last = 1'b1;
        end
        o_push_cnt = acc ? cnt : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (acc && pw_en) begin
            r_prefix[pw_idx] <= r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_held       <= 8'd0;
            r_held_valid <= 1'b0;
            r_consume    <= 1'b0;
            r_pos        <= '0;
            r_line       <= 16'd0;
            r_col        <= 16'd0;
            r_open_off   <= '0;
            r_open_line  <= 16'd0;
            r_open_col   <= 16'd0;
            r_len        <= 16'd0;
        end else if (acc) begin
            if (i_end_of_input) begin
                r_mode       <= MODE_IDLE;
                r_held       <= 8'd0;
                r_held_valid <= 1'b0;
                r_consume    <= 1'b0;
                r_pos        <= '0;
                r_line       <= 16'd0;
                r_col        <= 16'd0;
                r_open_off   <= '0;
                r_open_line  <= 16'd0;
                r_open_col   <= 16'd0;
                r_len        <= 16'd0;
            end else begin
                r_mode       <= n_mode;
                r_held       <= i_char_code;
                r_held_valid <= 1'b1;
                r_consume    <= n_consume;
                r_pos        <= n_pos;
                r_line       <= n_line;
                r_col        <= n_col;
                r_open_off   <= n_open_off;
                r_open_line  <= n_open_line;
                r_open_col   <= n_open_col;
                r_len        <= n_len;
            end
        end
    end

endmodule

// ===== design/stt_queue.sv =====
// ----------------------------------------------------------------------------
// stt_queue
// Record queue between lexer and output stage: up to two pushes and one pop
// per cycle.
// ----------------------------------------------------------------------------
module stt_queue #(
    parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_push_cnt,
    input  stt_pkg::t_rec          i_rec0,
    input  stt_pkg::t_rec          i_rec1,
    input  logic [OFFSET_BITS-1:0] i_off0,
    input  logic [OFFSET_BITS-1:0] i_off1,
    input  logic                   i_pop,
    output logic                   o_full,
    output logic                   o_avail,
    output stt_pkg::t_rec          o_rec,
    output logic [OFFSET_BITS-1:0] o_off
);
    import stt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_rec                   r_rec [QUEUE_DEPTH];
    logic [OFFSET_BITS-1:0] r_off [QUEUE_DEPTH];
    logic [PTR_W-1:0]       r_wr, n_wr;
    logic [PTR_W-1:0]       r_rd, n_rd;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [PTR_W-1:0]       wr1;

    assign wr1     = r_wr + 1'b1;
    assign o_full  = (r_count > CNT_W'(QUEUE_DEPTH - 2));
    assign o_avail = (r_count != '0);
    assign o_rec   = r_rec[r_rd];
    assign o_off   = r_off[r_rd];

    always_comb begin
        n_wr    = r_wr + PTR_W'(i_push_cnt);
        n_rd    = i_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count + CNT_W'(i_push_cnt) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_rec[r_wr] <= i_rec0;
            r_off[r_wr] <= i_off0;
        end
        if (i_push_cnt == 2'd2) begin
            r_rec[wr1] <= i_rec1;
            r_off[wr1] <= i_off1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ===== design/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back
// Output stage: takes records from the queue into the output register and
// hands them out under the valid and stall handshake.
// ----------------------------------------------------------------------------
module stt_back #(
    parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_avail,
    input  stt_pkg::t_rec          i_rec,
    input  logic [OFFSET_BITS-1:0] i_off,
    output logic                   o_pop,
    input  logic                   i_stall,
    output logic                   o_valid,
    output stt_pkg::t_rec          o_rec,
    output logic [OFFSET_BITS-1:0] o_off
);
    import stt_pkg::*;

    logic                   r_valid, n_valid;
    t_rec                   r_rec;
    logic [OFFSET_BITS-1:0] r_off;

    assign o_pop   = i_avail && (!r_valid || !i_stall);
    assign n_valid = o_pop || (r_valid && i_stall);
    assign o_valid = r_valid;
    assign o_rec   = r_rec;
    assign o_off   = r_off;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
            r_off <= i_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

// ===== design/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Byte-serial tokenizer emitting one record per keyword, identifier, number,
// symbol or string token.
// ----------------------------------------------------------------------------
// One source byte is accepted per cycle unless the input stalls. Each
// transaction yields zero, one or two token records; the lexer pushes them
// into a four-entry queue and the output register drains one record per cycle
// unless stalled, so input runs at one byte per cycle as long as bytes average
// no more than one record each, and the input stalls whenever the queue has
// fewer than two free entries. Each byte is held as lookahead and lexed as the
// following byte is accepted, so a word or number ends when the byte after its
// last byte is lexed; an end-of-input transaction lexes the held byte, flushes
// the open word or number and returns all position counters to zero. No
// clearing pass follows reset.
module source_text_tokenizer #(
    parameter int KEYWORD_MAX_LEN = stt_pkg::KW_MAX_LEN_DEF,
    parameter int OFFSET_BITS     = stt_pkg::OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [7:0]             i_char_code,
    input  logic                   i_end_of_input,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [2:0]             o_token_kind,
    output logic [OFFSET_BITS-1:0] o_start_offset,
    output logic [15:0]            o_token_length,
    output logic [15:0]            o_start_line,
    output logic [15:0]            o_start_column,
    output logic                   o_is_last
);
    import stt_pkg::*;

    logic                   full;
    logic [1:0]             push_cnt;
    t_rec                   rec0, rec1, q_rec, out_rec;
    logic [OFFSET_BITS-1:0] off0, off1, q_off;
    logic                   q_avail;
    logic                   pop;

    stt_front #(
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
        .OFFSET_BITS    (OFFSET_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_char_code   (i_char_code),
        .i_end_of_input(i_end_of_input),
        .i_full        (full),
        .o_stall       (o_stall),
        .o_push_cnt    (push_cnt),
        .o_rec0        (rec0),
        .o_rec1        (rec1),
        .o_off0        (off0),
        .o_off1        (off1)
    );

    stt_queue #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_cnt(push_cnt),
        .i_rec0    (rec0),
        .i_rec1    (rec1),
        .i_off0    (off0),
        .i_off1    (off1),
        .i_pop     (pop),
        .o_full    (full),
        .o_avail   (q_avail),
        .o_rec     (q_rec),
        .o_off     (q_off)
    );

    stt_back #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_avail(q_avail),
        .i_rec  (q_rec),
        .i_off  (q_off),
        .o_pop  (pop),
        .i_stall(i_stall),
        .o_valid(o_valid),
        .o_rec  (out_rec),
        .o_off  (o_start_offset)
    );

    assign o_token_kind   = out_rec.kind;
    assign o_token_length = out_rec.length;
    assign o_start_line   = out_rec.line;
    assign o_start_column = out_rec.column;
    assign o_is_last      = out_rec.last;

endmodule

// ===== dv/source_text_tokenizer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_tb
// Self-checking bench for the byte-serial tokenizer. A scoreboard class keeps
// its own lexer state, predicts the token records of every accepted byte and
// compares each record leaving the block field by field. Stimulus is a short
// directed text and random source fragments (keywords, words, numbers,
// symbols, strings, comments, whitespace, noise, end of input). Both handshake
// sides idle and stall at random.
// ----------------------------------------------------------------------------
import stt_pkg::*;

class token_scoreboard;
    localparam int OFF_W = OFFSET_BITS_DEF;
    localparam int KW_MAX = KW_MAX_LEN_DEF;
    localparam logic [OFF_W-1:0] OFF_MAX = '1;
    localparam logic [15:0] MAX16 = 16'hFFFF;

    typedef struct {
        t_kind            kind;
        logic [OFF_W-1:0] offset;
        logic [15:0]      length;
        logic [15:0]      line_no;
        logic [15:0]      column;
        logic             last;
    } token_t;

    string keywords[21] = '{
        "class", "constructor", "function", "method", "field", "static", "var",
        "int", "char", "boolean", "void", "true", "false", "null", "this",
        "let", "do", "if", "else", "while", "return"
    };

    token_t           pending_tokens[$];
    int               errors;

    t_mode            state;
    logic [7:0]       lookahead;
    bit               have_lookahead;
    bit               drop_lookahead;
    logic [OFF_W-1:0] cur_offset;
    logic [15:0]      cur_line;
    logic [15:0]      cur_col;
    logic [OFF_W-1:0] tok_offset;
    logic [15:0]      tok_line;
    logic [15:0]      tok_col;
    logic [15:0]      tok_len;
    logic [7:0]       word_bytes[KW_MAX];

    function new();
        errors = 0;
        clear();
    endfunction

    function void clear();
        state = MODE_IDLE;
        lookahead = '0;
        have_lookahead = 1'b0;
        drop_lookahead = 1'b0;
        cur_offset = '0;
        cur_line = '0;
        cur_col = '0;
        tok_offset = '0;
        tok_line = '0;
        tok_col = '0;
        tok_len = '0;
        foreach (word_bytes[i]) word_bytes[i] = '0;
    endfunction

    static function bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
    endfunction

    static function bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    static function bit is_break(logic [7:0] c);
        return c == CH_LF || c == CH_CR;
    endfunction

    static function bit is_symbol(logic [7:0] c);
        case (c)
            "&", "|", "=", "<", ">", "+", "-", CH_STAR, CH_SLASH, ".", ",",
            "(", ")", "[", "]", "{", "}", CH_TILDE, CH_SEMI: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function void push_token(t_kind kind, logic [OFF_W-1:0] off, logic [15:0] len,
                             logic [15:0] ln, logic [15:0] col);
        token_t t;
        t.kind = kind;
        t.offset = off;
        t.length = len;
        t.line_no = ln;
        t.column = col;
        t.last = 1'b0;
        pending_tokens.insert(pending_tokens.size(), t);
    endfunction

    function void push_open(t_kind kind);
        push_token(kind, tok_offset, tok_len, tok_line, tok_col);
    endfunction

    function t_kind word_kind();
        bit hit;
        if (tok_len > KW_MAX) return KIND_IDENT;
        foreach (keywords[i]) begin
            if (keywords[i].len() == tok_len) begin
                hit = 1'b1;
                for (int j = 0; j < keywords[i].len(); j++) begin
                    if (keywords[i][j] != word_bytes[j]) hit = 1'b0;
                end
                if (hit) return KIND_KEYWORD;
            end
        end
        return KIND_IDENT;
    endfunction

    function void open_token();
        tok_offset = cur_offset;
        tok_line = cur_line;
        tok_col = cur_col;
        tok_len = 16'd1;
    endfunction

    function void grow_token();
        if (tok_len < MAX16) tok_len++;
    endfunction

    function void start_token(logic [7:0] c, bit nv, logic [7:0] n);
        if (is_letter(c)) begin
            state = MODE_WORD;
            open_token();
            word_bytes[0] = c;
        end else if (is_digit(c)) begin
            state = MODE_NUMBER;
            open_token();
        end else if (c == CH_QUOTE) begin
            state = MODE_STRING;
            tok_offset = cur_offset < OFF_MAX ? cur_offset + 1'b1 : OFF_MAX;
            tok_line = cur_line;
            tok_col = cur_col < MAX16 ? cur_col + 1'b1 : MAX16;
            tok_len = '0;
        end else if (c == CH_SLASH && nv && n == CH_SLASH) begin
            state = MODE_LCOMMENT;
            drop_lookahead = 1'b1;
        end else if (c == CH_SLASH && nv && n == CH_STAR) begin
            state = MODE_BCOMMENT;
            drop_lookahead = 1'b1;
        end else if (is_symbol(c)) begin
            push_token(KIND_SYMBOL, cur_offset, 16'd1, cur_line, cur_col);
        end
    endfunction

    function void lex_byte(logic [7:0] c, bit nv, logic [7:0] n);
        case (state)
            MODE_WORD: begin
                if (is_letter(c) || is_digit(c)) begin
                    if (tok_len < KW_MAX) word_bytes[tok_len] = c;
                    grow_token();
                    return;
                end
                push_open(word_kind());
                state = MODE_IDLE;
            end
            MODE_NUMBER: begin
                if (is_digit(c)) begin
                    grow_token();
                    return;
                end
                push_open(KIND_NUMBER);
                state = MODE_IDLE;
            end
            MODE_STRING: begin
                if (c == CH_QUOTE || is_break(c)) begin
                    push_open(KIND_STRING);
                    state = MODE_IDLE;
                end else begin
                    grow_token();
                end
                return;
            end
            MODE_LCOMMENT: begin
                if (is_break(c)) state = MODE_IDLE;
                return;
            end
            MODE_BCOMMENT: begin
                if (c == CH_STAR && nv && n == CH_SLASH) begin
                    state = MODE_IDLE;
                    drop_lookahead = 1'b1;
                end
                return;
            end
            default: state = MODE_IDLE;
        endcase
        start_token(c, nv, n);
    endfunction

    function void move_position(logic [7:0] c);
        if (is_break(c)) begin
            if (cur_line < MAX16) cur_line++;
            cur_col = '0;
        end else if (cur_col < MAX16) begin
            cur_col++;
        end
        if (cur_offset < OFF_MAX) cur_offset++;
    endfunction

    function void note_byte(logic [7:0] c, bit eoi);
        int first;
        first = pending_tokens.size();
        if (have_lookahead) begin
            if (drop_lookahead) drop_lookahead = 1'b0;
            else lex_byte(lookahead, !eoi, c);
            move_position(lookahead);
        end
        if (eoi) begin
            if (state == MODE_WORD) push_open(word_kind());
            else if (state == MODE_NUMBER) push_open(KIND_NUMBER);
            clear();
        end else begin
            lookahead = c;
            have_lookahead = 1'b1;
        end
        if (pending_tokens.size() > first) pending_tokens[pending_tokens.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
        if (actual !== expected) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            errors++;
        end
    endfunction

    function void check_token(logic [2:0] kind, logic [OFF_W-1:0] off, logic [15:0] len,
                              logic [15:0] ln, logic [15:0] col, logic last);
        token_t t;
        if (pending_tokens.size() == 0) begin
            $error("token record with none expected: kind %0d, offset %0d", kind, off);
            errors++;
            return;
        end
        t = pending_tokens.pop_front();
        compare_field("token_kind", t.kind, kind);
        compare_field("start_offset", t.offset, off);
        compare_field("token_length", t.length, len);
        compare_field("start_line", t.line_no, ln);
        compare_field("start_column", t.column, col);
        compare_field("is_last", t.last, last);
    endfunction
endclass

module source_text_tokenizer_tb;
    localparam int OFF_W = OFFSET_BITS_DEF;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_ITEMS = 1600;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [7:0]       i_char_code = '0;
    logic             i_end_of_input = 1'b0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [2:0]       o_token_kind;
    logic [OFF_W-1:0] o_start_offset;
    logic [15:0]      o_token_length;
    logic [15:0]      o_start_line;
    logic [15:0]      o_start_column;
    logic             o_is_last;

    token_scoreboard sb = new();
    bit              tx_idle = 1'b1;
    bit              rx_idle = 1'b1;
    int              sent_items = 0;
    int              cycles = 0;
    string           symbol_set = "&|=<>+-*/.,()[]{}~;";

    source_text_tokenizer uut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("source_text_tokenizer_tb failed");
            $finish;
        end
    end

    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            hold = rx_idle ? $urandom_range(0, 13) : 0;
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            sb.check_token(o_token_kind, o_start_offset, o_token_length, o_start_line,
                           o_start_column, o_is_last);
        end
    end

    task automatic send_byte(input logic [7:0] c, input bit eoi);
        int gap;
        gap = tx_idle ? $urandom_range(0, 13) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_code <= c;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(c, eoi);
        sent_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    task automatic send_eoi();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_tokens.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return CH_UNDERSCORE;
    endfunction

    function automatic logic [7:0] rand_word_char();
        if ($urandom_range(0, 3) == 0) return 8'(CH_ZERO + $urandom_range(0, 9));
        return rand_letter();
    endfunction

    function automatic logic [7:0] rand_string_char();
        logic [7:0] c;
        do begin
            if ($urandom_range(0, 3) != 0) c = 8'($urandom_range(32, 126));
            else c = 8'($urandom_range(0, 255));
        end while (c == CH_QUOTE || c == CH_LF || c == CH_CR);
        return c;
    endfunction

    task automatic send_fragment();
        int    pick;
        int    n;
        string kw;
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            send_text(sb.keywords[$urandom_range(0, 20)]);
        end else if (pick < 26) begin
            // keyword with extra word bytes, or cut short
            kw = sb.keywords[$urandom_range(0, 20)];
            if ($urandom_range(0, 1)) begin
                send_text(kw);
                repeat ($urandom_range(1, 3)) send_byte(rand_word_char(), 1'b0);
            end else begin
                send_text(kw.substr(0, $urandom_range(0, kw.len() - 2)));
            end
        end else if (pick < 41) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
            send_byte(rand_letter(), 1'b0);
            repeat (n - 1) send_byte(rand_word_char(), 1'b0);
        end else if (pick < 51) begin
            repeat ($urandom_range(1, 6)) send_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
        end else if (pick < 66) begin
            send_byte(symbol_set[$urandom_range(0, symbol_set.len() - 1)], 1'b0);
        end else if (pick < 74) begin
            send_byte(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 8)) send_byte(rand_string_char(), 1'b0);
            if ($urandom_range(0, 5) == 0) send_byte($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0);
            else send_byte(CH_QUOTE, 1'b0);
        end else if (pick < 79) begin
            send_text("//");
            repeat ($urandom_range(0, 6)) send_byte(rand_string_char(), 1'b0);
            send_byte($urandom_range(0, 1) ? CH_LF : CH_CR, 1'b0);
        end else if (pick < 84) begin
            send_text("/*");
            repeat ($urandom_range(0, 6)) begin
                case ($urandom_range(0, 4))
                    0: send_byte(CH_STAR, 1'b0);
                    1: send_byte(CH_SLASH, 1'b0);
                    2: send_byte(CH_LF, 1'b0);
                    default: send_byte(rand_string_char(), 1'b0);
                endcase
            end
            send_text("*/");
        end else if (pick < 92) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 3))
                    0: send_byte(" ", 1'b0);
                    1: send_byte("\t", 1'b0);
                    2: send_byte(CH_CR, 1'b0);
                    default: send_byte(CH_LF, 1'b0);
                endcase
            end
        end else if (pick < 98) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            send_eoi();
        end
        if ($urandom_range(0, 2) == 0) send_byte(" ", 1'b0);
    endtask

    task automatic run_random(input int count);
        int target;
        target = sent_items + count;
        while (sent_items < target) begin
            if ($urandom_range(0, 29) == 0) begin
                tx_idle = $urandom_range(0, 3) != 0;
                rx_idle = $urandom_range(0, 3) != 0;
            end
            send_fragment();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_text("if 42;\"\"\"a\015\n/*/*/");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("constructor_");
        send_eoi();
        send_text("\"s");
        send_eoi();
        wait_drained();

        run_random(RANDOM_ITEMS / 2);
        wait_drained();
        run_random(RANDOM_ITEMS / 2);

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_tokens.size() == 0) begin
            $display("source_text_tokenizer_tb passed");
        end else begin
            $display("source_text_tokenizer_tb failed");
        end
        $finish;
    end
endmodule
